// ===== design/bwc_pkg.sv =====
// ----------------------------------------------------------------------------
// bwc_pkg
// Shared types, constants and helper functions for the Butterworth
// coefficient designer.
// ----------------------------------------------------------------------------
package bwc_pkg;

  localparam int MAX_ORDER       = 8;
  localparam int MAX_TERMS       = 9;
  localparam int COEFF_FRAC_BITS = 24;
  localparam int POLY_FRAC       = 24;
  localparam int CORDIC_STEPS    = 30;

  localparam int ORD_W   = 4;
  localparam int TERM_AW = $clog2(MAX_TERMS);
  localparam int POLE_AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int Q_W     = 32;
  localparam int CX_W    = 34;
  localparam int POLY_W  = 40;
  localparam int ACC_W   = 46;
  localparam int MUL_W   = 44;
  localparam int SUM_W   = 44;
  localparam int DVD_W   = 62;
  localparam int DSR_W   = 32;
  localparam int BIN_W   = 8;
  localparam int PROD_W  = SUM_W + BIN_W + 1;

  localparam int OUT_SHR = (POLY_FRAC > COEFF_FRAC_BITS) ? POLY_FRAC - COEFF_FRAC_BITS : 0;
  localparam int OUT_SHL = (COEFF_FRAC_BITS > POLY_FRAC) ? COEFF_FRAC_BITS - POLY_FRAC : 0;

  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic [3:0]  filter_order;
    logic [14:0] cutoff_ratio;
  } bwc_in_t;

  typedef struct packed {
    logic [3:0]         coeff_index;
    logic signed [31:0] denom_coeff;
    logic signed [31:0] numer_coeff;
    logic               last_coeff;
  } bwc_out_t;

  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] s);
    logic [31:0] v;
    case (s)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [BIN_W-1:0] binom_coef(input logic [ORD_W-1:0] n,
                                                  input logic [TERM_AW-1:0] k);
    logic [BIN_W-1:0] row [0:MAX_TERMS-1];
    for (int b = 0; b < MAX_TERMS; b++) row[b] = (b == 0) ? BIN_W'(1) : '0;
    for (int a = 0; a < MAX_ORDER; a++) begin
      if (a < int'(n)) begin
        for (int b = MAX_TERMS - 1; b > 0; b--) row[b] = row[b] + row[b-1];
      end
    end
    return row[k];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [POLY_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
    logic signed [POLY_W-1:0] r;
    logic signed [ACC_W-1:0]  hi;
    logic signed [ACC_W-1:0]  lo;
    hi = ACC_W'((64'sd1 <<< (POLY_W - 1)) - 64'sd1);
    lo = -hi - ACC_W'(1);
    if (v > hi) r = hi[POLY_W-1:0];
    else if (v < lo) r = lo[POLY_W-1:0];
    else r = v[POLY_W-1:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_mag32(input logic neg,
                                                   input logic [DVD_W-1:0] mag);
    logic signed [31:0] r;
    if (!neg) r = (mag > DVD_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(mag[31:0]);
    else r = (mag > DVD_W'(32'h80000000)) ? 32'sh80000000 : -$signed(mag[31:0]);
    return r;
  endfunction

  function automatic logic signed [31:0] sat_out(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v >>> OUT_SHR) <<< OUT_SHL;
    return sat32(t);
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== design/bwc_cordic.sv =====
// ----------------------------------------------------------------------------
// bwc_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, sine and cosine
// of a binary angle in the range zero to a half turn.
// ----------------------------------------------------------------------------
module bwc_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        ang,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import bwc_pkg::*;

  logic signed [CX_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   run_r, run_nxt, done_r, done_nxt, flip_r, flip_nxt;
  logic [31:0]            a_c, a_f;
  logic signed [CX_W-1:0] xs, ys, at;

  assign xs = x_r >>> step_r;
  assign ys = y_r >>> step_r;
  assign at = $signed({2'b00, atan_turn(step_r)});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    a_c      = (ang > 32'h80000000) ? 32'h80000000 : ang;
    a_f      = (a_c > 32'h40000000) ? (32'h80000000 - a_c) : a_c;
    if (start) begin
      flip_nxt = a_c > 32'h40000000;
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = $signed({2'b00, a_f});
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!z_r[CX_W-1]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    flip_r <= flip_nxt;
  end

  assign done  = done_r;
  assign sin_o = y_r[31:0];
  assign cos_o = flip_r ? -x_r[31:0] : x_r[31:0];

endmodule

// ===== design/bwc_mul.sv =====
// ----------------------------------------------------------------------------
// bwc_mul
// Sign-magnitude Q30 multiplier: 40-bit by 32-bit through one 20x32
// multiplier over two passes, product scaled down by 2^30, truncated.
// ----------------------------------------------------------------------------
module bwc_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [bwc_pkg::POLY_W-1:0] a,
  input  logic signed [31:0]               b,
  output logic                             done,
  output logic signed [bwc_pkg::MUL_W-1:0] p
);
  import bwc_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LO   = 2'd1;
  localparam logic [1:0] PH_HI   = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]            ph_r, ph_nxt;
  logic                  done_r, done_nxt;
  logic [POLY_W-1:0]     ua_r;
  logic [31:0]           ub_r;
  logic                  neg_r;
  logic [51:0]           lo_r, hi_r, prod;
  logic [19:0]           half;
  logic [52:0]           total;
  logic [MUL_W-2:0]      mag;
  logic signed [MUL_W-1:0] p_r;

  assign half  = (ph_r == PH_LO) ? ua_r[19:0] : ua_r[39:20];
  assign prod  = {32'd0, half} * {20'd0, ub_r};
  assign total = {1'b0, hi_r} + {21'd0, lo_r[51:20]};
  assign mag   = total[52:10];

  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    case (ph_r)
      PH_IDLE: if (start) ph_nxt = PH_LO;
      PH_LO:   ph_nxt = PH_HI;
      PH_HI:   ph_nxt = PH_SUM;
      PH_SUM: begin
        ph_nxt   = PH_IDLE;
        done_nxt = 1'b1;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && ph_r == PH_IDLE) begin
      ua_r  <= a[POLY_W-1] ? (~a + POLY_W'(1)) : a;
      ub_r  <= abs32(b);
      neg_r <= a[POLY_W-1] ^ b[31];
    end
    if (ph_r == PH_LO) lo_r <= prod;
    if (ph_r == PH_HI) hi_r <= prod;
    if (ph_r == PH_SUM) p_r <= neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== design/bwc_div.sv =====
// ----------------------------------------------------------------------------
// bwc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bwc_pkg::DVD_W-1:0] dvd,
  input  logic [bwc_pkg::DSR_W-1:0] dsr,
  output logic                      done,
  output logic [bwc_pkg::DVD_W-1:0] quo
);
  import bwc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt, d_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt, done_r, done_nxt;
  logic [DSR_W:0]   sh;
  logic [DSR_W+1:0] diff;

  assign sh   = {rem_r, q_r[DVD_W-1]};
  assign diff = {1'b0, sh} - {2'b00, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt   = dvd;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!diff[DSR_W+1]) begin
        rem_nxt = diff[DSR_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[DSR_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (start) d_r <= dsr;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== design/butterworth_coeff_synth.sv =====
// ----------------------------------------------------------------------------
// butterworth_coeff_synth
// Butterworth low-pass designer: bilinear-mapped poles, polynomial
// expansion and binomial numerator, emitted one coefficient per transfer.
// ----------------------------------------------------------------------------
// Usage: present a request (filter_order, cutoff_ratio) on in_valid/in_data;
// it is taken when in_ready is high. in_ready stays low until the last
// coefficient of the request has been transferred on the out_ channel.
// Each request yields N+1 transfers, index 0 (z^N term) first, last_coeff
// set on the final one. N is filter_order clamped to 1..8.
// Sequencing: the pole stage runs each pole through the divider and the
// 30-step CORDIC; the expansion does four shared multiplies per polynomial
// entry update. One request at a time.
// A low out_ready stalls the sequencer on the current coefficient, which
// stays on out_data until transferred. Reset (rst_n low, synchronous)
// returns the block to idle and drops any request in progress.
// ----------------------------------------------------------------------------
module butterworth_coeff_synth (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwc_pkg::bwc_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bwc_pkg::bwc_out_t  out_data
);
  import bwc_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_WARP   = 5'd1;
  localparam logic [4:0] S_ANG    = 5'd2;
  localparam logic [4:0] S_ANG_W  = 5'd3;
  localparam logic [4:0] S_SC     = 5'd4;
  localparam logic [4:0] S_SC_W   = 5'd5;
  localparam logic [4:0] S_DEN    = 5'd6;
  localparam logic [4:0] S_DEN_W  = 5'd7;
  localparam logic [4:0] S_RE     = 5'd8;
  localparam logic [4:0] S_RE_W   = 5'd9;
  localparam logic [4:0] S_IMM    = 5'd10;
  localparam logic [4:0] S_IMM_W  = 5'd11;
  localparam logic [4:0] S_IM     = 5'd12;
  localparam logic [4:0] S_IM_W   = 5'd13;
  localparam logic [4:0] S_PINIT  = 5'd14;
  localparam logic [4:0] S_PLOAD  = 5'd15;
  localparam logic [4:0] S_PMUL   = 5'd16;
  localparam logic [4:0] S_PMUL_W = 5'd17;
  localparam logic [4:0] S_PWR    = 5'd18;
  localparam logic [4:0] S_SUM    = 5'd19;
  localparam logic [4:0] S_ECALC  = 5'd20;
  localparam logic [4:0] S_EOUT   = 5'd21;
  localparam logic [4:0] S_EHOLD  = 5'd22;

  localparam logic [1:0] K_RR = 2'd0;
  localparam logic [1:0] K_II = 2'd1;
  localparam logic [1:0] K_RI = 2'd2;
  localparam logic [1:0] K_IR = 2'd3;

  logic [4:0]               state_r, state_nxt;
  logic [ORD_W-1:0]         n_r, n_nxt, idx_r, idx_nxt;
  logic [TERM_AW-1:0]       j_r, j_nxt, o_r, o_nxt;
  logic [1:0]               k_r, k_nxt;
  logic signed [31:0]       warp_factor_r, warp_factor_nxt, c2_r, c2_nxt;
  logic signed [31:0]       sn_r, sn_nxt, cs_r, cs_nxt;
  logic [31:0]              den_r, den_nxt;
  logic signed [MUL_W-1:0]  mim_r, mim_nxt;
  logic signed [POLY_W-1:0] cur_re_r, cur_re_nxt, cur_im_r, cur_im_nxt;
  logic signed [POLY_W-1:0] prev_re_r, prev_re_nxt, prev_im_r, prev_im_nxt;
  logic signed [ACC_W-1:0]  acc_re_r, acc_re_nxt, acc_im_r, acc_im_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [31:0]       dco_r, dco_nxt;
  logic                     out_valid_r, out_valid_nxt;
  bwc_out_t                 out_r, out_nxt;

  logic signed [31:0]       pole_re_r [0:MAX_ORDER-1];
  logic signed [31:0]       pole_im_r [0:MAX_ORDER-1];
  logic signed [POLY_W-1:0] poly_re_r [0:MAX_TERMS-1];
  logic signed [POLY_W-1:0] poly_im_r [0:MAX_TERMS-1];

  logic                     pole_re_we, pole_im_we, poly_we;
  logic signed [31:0]       pole_wd;
  logic [TERM_AW-1:0]       poly_wa, rd_addr;
  logic signed [POLY_W-1:0] poly_wd_re, poly_wd_im, rd_re, rd_im;
  logic signed [31:0]       pole_pr, pole_pi;

  logic                     cor_start, cor_done;
  logic [31:0]              cor_ang;
  logic signed [31:0]       cor_sin, cor_cos;
  logic                     mul_start, mul_done;
  logic signed [POLY_W-1:0] mul_a;
  logic signed [31:0]       mul_b;
  logic signed [MUL_W-1:0]  mul_p;
  logic                     div_start, div_done;
  logic [DVD_W-1:0]         div_dvd, div_quo;
  logic [DSR_W-1:0]         div_dsr;

  logic signed [MUL_W:0]    den_full;
  logic [ORD_W-1:0]         n_in;
  logic [MUL_W-1:0]         mim_abs;

  bwc_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .ang(cor_ang),
    .done(cor_done), .sin_o(cor_sin), .cos_o(cor_cos)
  );

  bwc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  bwc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dsr(div_dsr),
    .done(div_done), .quo(div_quo)
  );

  assign pole_pr = pole_re_r[idx_r[POLE_AW-1:0]];
  assign pole_pi = pole_im_r[idx_r[POLE_AW-1:0]];
  assign rd_re   = poly_re_r[rd_addr];
  assign rd_im   = poly_im_r[rd_addr];
  assign den_full = $signed({{(MUL_W-31){1'b0}}, 32'h40000000})
                    + $signed({mul_p[MUL_W-1], mul_p});
  assign mim_abs = mim_r[MUL_W-1] ? (~mim_r + MUL_W'(1)) : mim_r;
  assign n_in = (in_data.filter_order == '0) ? ORD_W'(1) :
                (in_data.filter_order > ORD_W'(MAX_ORDER)) ? ORD_W'(MAX_ORDER) :
                in_data.filter_order;

  always_comb begin
    case (state_r)
      S_PLOAD: rd_addr = j_r - TERM_AW'(1);
      S_SUM:   rd_addr = j_r;
      default: rd_addr = n_r[TERM_AW-1:0] - o_r;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    j_nxt           = j_r;
    o_nxt           = o_r;
    k_nxt           = k_r;
    warp_factor_nxt = warp_factor_r;
    c2_nxt          = c2_r;
    sn_nxt          = sn_r;
    cs_nxt          = cs_r;
    den_nxt         = den_r;
    mim_nxt         = mim_r;
    cur_re_nxt      = cur_re_r;
    cur_im_nxt      = cur_im_r;
    prev_re_nxt     = prev_re_r;
    prev_im_nxt     = prev_im_r;
    acc_re_nxt      = acc_re_r;
    acc_im_nxt      = acc_im_r;
    sum_nxt         = sum_r;
    prod_nxt        = prod_r;
    dco_nxt         = dco_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    cor_start       = 1'b0;
    cor_ang         = '0;
    mul_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    div_start       = 1'b0;
    div_dvd         = '0;
    div_dsr         = '0;
    pole_re_we      = 1'b0;
    pole_im_we      = 1'b0;
    pole_wd         = sat_mag32(c2_r[31], div_quo);
    poly_we         = 1'b0;
    poly_wa         = j_r;
    poly_wd_re      = sat40(acc_re_r);
    poly_wd_im      = sat40(acc_im_r);
    case (state_r)
      S_IDLE: begin
        cor_ang = {1'b0, in_data.cutoff_ratio, 16'd0};
        if (in_valid) begin
          n_nxt     = n_in;
          cor_start = 1'b1;
          state_nxt = S_WARP;
        end
      end
      S_WARP: begin
        if (cor_done) begin
          warp_factor_nxt = cor_sin;
          c2_nxt          = cor_cos;
          idx_nxt         = '0;
          state_nxt       = S_ANG;
        end
      end
      S_ANG: begin
        div_start = 1'b1;
        div_dvd   = ({{(DVD_W-4){1'b0}}, idx_r[2:0], 1'b1} << 30)
                    + DVD_W'(n_r >> 1);
        div_dsr   = DSR_W'(n_r);
        state_nxt = S_ANG_W;
      end
      S_ANG_W: if (div_done) state_nxt = S_SC;
      S_SC: begin
        cor_start = 1'b1;
        cor_ang   = div_quo[31:0];
        state_nxt = S_SC_W;
      end
      S_SC_W: begin
        if (cor_done) begin
          sn_nxt    = cor_sin;
          cs_nxt    = cor_cos;
          state_nxt = S_DEN;
        end
      end
      S_DEN: begin
        mul_start = 1'b1;
        mul_a     = POLY_W'(sn_r);
        mul_b     = warp_factor_r;
        state_nxt = S_DEN_W;
      end
      S_DEN_W: begin
        if (mul_done) begin
          den_nxt   = (den_full < 1) ? 32'd1 : den_full[31:0];
          state_nxt = S_RE;
        end
      end
      S_RE: begin
        div_start = 1'b1;
        div_dvd   = {abs32(c2_r), 30'd0};
        div_dsr   = den_r;
        state_nxt = S_RE_W;
      end
      S_RE_W: begin
        if (div_done) begin
          pole_re_we = 1'b1;
          state_nxt  = S_IMM;
        end
      end
      S_IMM: begin
        mul_start = 1'b1;
        mul_a     = POLY_W'(cs_r);
        mul_b     = warp_factor_r;
        state_nxt = S_IMM_W;
      end
      S_IMM_W: begin
        if (mul_done) begin
          mim_nxt   = mul_p;
          state_nxt = S_IM;
        end
      end
      S_IM: begin
        div_start = 1'b1;
        div_dvd   = {mim_abs[31:0], 30'd0};
        div_dsr   = den_r;
        state_nxt = S_IM_W;
      end
      S_IM_W: begin
        pole_wd = sat_mag32(mim_r[MUL_W-1], div_quo);
        if (div_done) begin
          pole_im_we = 1'b1;
          if (idx_r + ORD_W'(1) == n_r) begin
            state_nxt = S_PINIT;
          end else begin
            idx_nxt   = idx_r + ORD_W'(1);
            state_nxt = S_ANG;
          end
        end
      end
      S_PINIT: begin
        poly_we    = 1'b1;
        poly_wa    = '0;
        poly_wd_re = POLY_W'(64'sd1 <<< POLY_FRAC);
        poly_wd_im = '0;
        idx_nxt    = '0;
        j_nxt      = TERM_AW'(1);
        cur_re_nxt = '0;
        cur_im_nxt = '0;
        state_nxt  = S_PLOAD;
      end
      S_PLOAD: begin
        prev_re_nxt = (j_r == '0) ? '0 : rd_re;
        prev_im_nxt = (j_r == '0) ? '0 : rd_im;
        acc_re_nxt  = ACC_W'(prev_re_nxt);
        acc_im_nxt  = ACC_W'(prev_im_nxt);
        k_nxt       = K_RR;
        state_nxt   = S_PMUL;
      end
      S_PMUL: begin
        mul_start = 1'b1;
        case (k_r)
          K_RR:    begin mul_a = cur_re_r; mul_b = pole_pr; end
          K_II:    begin mul_a = cur_im_r; mul_b = pole_pi; end
          K_RI:    begin mul_a = cur_re_r; mul_b = pole_pi; end
          default: begin mul_a = cur_im_r; mul_b = pole_pr; end
        endcase
        state_nxt = S_PMUL_W;
      end
      S_PMUL_W: begin
        if (mul_done) begin
          case (k_r)
            K_RR:    acc_re_nxt = acc_re_r - ACC_W'(mul_p);
            K_II:    acc_re_nxt = acc_re_r + ACC_W'(mul_p);
            K_RI:    acc_im_nxt = acc_im_r - ACC_W'(mul_p);
            default: acc_im_nxt = acc_im_r - ACC_W'(mul_p);
          endcase
          if (k_r == K_IR) begin
            state_nxt = S_PWR;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_PMUL;
          end
        end
      end
      S_PWR: begin
        poly_we    = 1'b1;
        cur_re_nxt = prev_re_r;
        cur_im_nxt = prev_im_r;
        if (j_r == '0) begin
          if (idx_r + ORD_W'(1) == n_r) begin
            j_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = S_SUM;
          end else begin
            idx_nxt    = idx_r + ORD_W'(1);
            j_nxt      = TERM_AW'(idx_r) + TERM_AW'(2);
            cur_re_nxt = '0;
            cur_im_nxt = '0;
            state_nxt  = S_PLOAD;
          end
        end else begin
          j_nxt     = j_r - TERM_AW'(1);
          state_nxt = S_PLOAD;
        end
      end
      S_SUM: begin
        sum_nxt = sum_r + SUM_W'(rd_re);
        if (j_r == TERM_AW'(n_r)) begin
          o_nxt     = '0;
          state_nxt = S_ECALC;
        end else begin
          j_nxt = j_r + TERM_AW'(1);
        end
      end
      S_ECALC: begin
        prod_nxt  = $signed({1'b0, binom_coef(n_r, o_r)}) * sum_r;
        dco_nxt   = sat_out(64'(rd_re));
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        out_nxt.coeff_index = 4'(o_r);
        out_nxt.denom_coeff = dco_r;
        out_nxt.numer_coeff = sat_out(64'(prod_r >>> n_r));
        out_nxt.last_coeff  = (o_r == TERM_AW'(n_r));
        out_valid_nxt       = 1'b1;
        state_nxt           = S_EHOLD;
      end
      S_EHOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_coeff) begin
            state_nxt = S_IDLE;
          end else begin
            o_nxt     = o_r + TERM_AW'(1);
            state_nxt = S_ECALC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      warp_factor_r <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      warp_factor_r <= warp_factor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    o_r       <= o_nxt;
    k_r       <= k_nxt;
    c2_r      <= c2_nxt;
    sn_r      <= sn_nxt;
    cs_r      <= cs_nxt;
    den_r     <= den_nxt;
    mim_r     <= mim_nxt;
    cur_re_r  <= cur_re_nxt;
    cur_im_r  <= cur_im_nxt;
    prev_re_r <= prev_re_nxt;
    prev_im_r <= prev_im_nxt;
    acc_re_r  <= acc_re_nxt;
    acc_im_r  <= acc_im_nxt;
    sum_r     <= sum_nxt;
    prod_r    <= prod_nxt;
    dco_r     <= dco_nxt;
    out_r     <= out_nxt;
    if (pole_re_we) pole_re_r[idx_r[POLE_AW-1:0]] <= pole_wd;
    if (pole_im_we) pole_im_r[idx_r[POLE_AW-1:0]] <= pole_wd;
    if (poly_we) begin
      poly_re_r[poly_wa] <= poly_wd_re;
      poly_im_r[poly_wa] <= poly_wd_im;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
